>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/deq_pkg.sv
// Types and constants of the double-ended queue with search.
package deq_pkg;

  localparam int unsigned DepthDef  = 16;
  localparam int unsigned GroupWDef = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_SHIFT_R = 2'd1,
    CELL_SHIFT_L = 2'd2,
    CELL_LOAD    = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CMP  = 2'd1,
    FSM_GRP  = 2'd2,
    FSM_FIN  = 2'd3
  } fsm_e;

  typedef struct packed {
    cell_op_e op;
    logic     in_use;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [4:0] entry_count;
    logic       is_empty;
    logic       found;
    logic [1:0] status;
  } out_t;

endpackage

>>> rtl/core/double_ended_queue_with_search.sv
// Top level of the bounded double-ended queue with membership search.
// The store is a row of DEPTH cells with the front entry in cell 0: a push at
// the front shifts the whole row one cell towards the back, a pop at the front
// shifts it one cell towards the front, a push at the back loads the cell just
// past the last entry and a pop at the back only lowers the count. Every beat
// in gives exactly one beat out carrying the count, the empty flag, the found
// flag and a status (push refused when full, pop ignored when empty). Push,
// pop, clear and the unused mode codes queue their result when the beat is
// taken; a search runs in steps: the key is held, every cell registers its
// compare, the hits are ORed in registered groups of 32 cells, then the result
// is queued. The search path sets the item rate, since the block takes one item
// at a time. Results wait in a two-entry output queue, so a new beat is taken
// while a result is still waiting. There is no clearing pass after reset.
`include "assert_macros.svh"

module double_ended_queue_with_search
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH  = DepthDef,
  parameter int unsigned GROUPW = GroupWDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  fsm_e            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic signed [31:0] key_q;

  logic acc;        // input beat taken this cycle
  logic fin;        // search result ready to queue
  logic res_push;   // write into the output queue
  logic fifo_room;
  logic full, empty;
  logic found_any;
  logic front_push; // front push that the store takes
  status_e status;
  out_t    res;

  // Output queue, two entries
  out_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fcnt_q;
  logic       res_pop;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign fifo_room = (fcnt_q != 2'd2) || out_ready_i;
  assign acc       = in_valid_i && in_ready_o;
  assign res_pop   = out_valid_o && out_ready_i;

  assign front_push = acc && (mode_e'(in_data_i.mode) == MODE_PUSH_FRONT) && !full;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (acc && (mode_e'(in_data_i.mode) == MODE_SEARCH)) begin
          state_d = FSM_CMP;
        end
      end
      FSM_CMP: state_d = FSM_GRP;
      FSM_GRP: state_d = FSM_FIN;
      FSM_FIN: state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    fin        = 1'b0;
    case (state_q)
      FSM_IDLE: in_ready_o = fifo_room;
      FSM_FIN:  fin        = 1'b1;
      default: begin
        in_ready_o = 1'b0;
        fin        = 1'b0;
      end
    endcase
  end

  // Count update and status for the push, pop and clear operations
  always_comb begin
    count_d = count_q;
    status  = ST_DONE;
    if (acc) begin
      case (mode_e'(in_data_i.mode))
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        MODE_CLEAR: count_d = '0;
        default:    count_d = count_q;
      endcase
    end
  end

  // Result word: search results come from the reduction, all else at once
  always_comb begin
    res.entry_count = 5'(count_d);
    res.is_empty    = (count_d == '0);
    res.found       = fin ? found_any : 1'b0;
    res.status      = fin ? ST_DONE : status;
  end

  assign res_push = (acc && (mode_e'(in_data_i.mode) != MODE_SEARCH)) || fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fcnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (res_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({res_push, res_pop})
        2'b10:   fcnt_q <= fcnt_q + 2'd1;
        2'b01:   fcnt_q <= fcnt_q - 2'd1;
        default: fcnt_q <= fcnt_q;
      endcase
    end
  end

  // Hold the key for the compare stage; queue payloads need no reset
  always_ff @(posedge clk_i) begin
    if (acc) begin
      key_q <= in_data_i.value;
    end
    if (res_push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o = (fcnt_q != 2'd0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  logic signed [31:0] cell_data [DEPTH];
  logic [DEPTH-1:0]   cell_match;
  cell_ctrl_t         cell_ctrl [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_w, right_w;

    // Feed the pushed word into the front; the last cell keeps its own word.
    if (i == 0) begin : g_first
      assign left_w = in_data_i.value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    always_comb begin
      cell_ctrl[i].op     = CELL_HOLD;
      cell_ctrl[i].in_use = (CntW'(i) < count_q);
      if (acc) begin
        case (mode_e'(in_data_i.mode))
          MODE_PUSH_FRONT: if (!full) cell_ctrl[i].op = CELL_SHIFT_R;
          MODE_PUSH_BACK: begin
            if (!full && (count_q == CntW'(i))) begin
              cell_ctrl[i].op = CELL_LOAD;
            end
          end
          MODE_POP_FRONT:  if (!empty) cell_ctrl[i].op = CELL_SHIFT_L;
          default:         cell_ctrl[i].op = CELL_HOLD;
        endcase
      end
    end

    deq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl[i]),
      .left_i     (left_w),
      .right_i    (right_w),
      .load_val_i (in_data_i.value),
      .key_i      (key_q),
      .data_o     (cell_data[i]),
      .match_o    (cell_match[i])
    );
  end

  deq_hit_reduce #(
    .Depth  (DEPTH),
    .GroupW (GROUPW)
  ) u_hit_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (cell_match),
    .any_o   (found_any)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_AT(a_count_bound, count_q <= CntW'(DEPTH), "entry count beyond depth")
  `ASSERT_AT(a_fifo_bound, fcnt_q <= 2'd2, "output queue overflow")
  `ASSERT_AT(a_busy_stall, (state_q != FSM_IDLE) |-> !in_ready_o, "beat taken mid-search")
  `ASSERT_AT(a_front_push, front_push |=> cell_data[0] == $past(in_data_i.value), "front push lost")

endmodule

>>> rtl/core/deq_cell.sv
// One storage cell of the deque row: holds a word, shifts, loads and compares.
module deq_cell
  import deq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] load_val_i,
  input  logic signed [31:0] key_i,
  output logic signed [31:0] data_o,
  output logic               match_o
);

  logic signed [31:0] data_q, data_d;
  logic               match_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_SHIFT_R: data_d = left_i;
      CELL_SHIFT_L: data_d = right_i;
      CELL_LOAD:    data_d = load_val_i;
      default:      data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Register the compare; only stored cells may hit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= ctrl_i.in_use && (data_q == key_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

>>> rtl/core/deq_hit_reduce.sv
// Registered OR reduction of the cell hit flags, one group register per slice.
module deq_hit_reduce
  import deq_pkg::*;
#(
  parameter int unsigned Depth  = DepthDef,
  parameter int unsigned GroupW = GroupWDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [Depth-1:0] match_i,
  output logic             any_o
);

  localparam int unsigned NGroups = (Depth + GroupW - 1) / GroupW;
  localparam int unsigned PadW    = NGroups * GroupW;

  logic [PadW-1:0]    match_pad;
  logic [NGroups-1:0] grp_q, grp_d;

  assign match_pad = PadW'(match_i);

  always_comb begin
    for (int g = 0; g < NGroups; g++) begin
      grp_d[g] = |match_pad[g*GroupW +: GroupW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else begin
      grp_q <= grp_d;
    end
  end

  assign any_o = |grp_q;

endmodule
